// ----- design/bld_pkg.sv -----
package bld_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int OP_W  = 3;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int NUM_W = 7;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_ERASE      = 3'd4;
	localparam logic [OP_W-1:0] OP_COUNT      = 3'd5;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic signed [VAL_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] popped_value;
		logic [NUM_W-1:0]        match_count;
		logic [NUM_W-1:0]        list_size;
		logic                    is_empty;
		logic signed [VAL_W-1:0] front_value;
		logic signed [VAL_W-1:0] back_value;
	} rsp_word_t;

endpackage

// ----- design/bld_ram.sv -----
module bld_ram #(
	parameter int DEPTH = bld_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [bld_pkg::VAL_W-1:0]    wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [bld_pkg::VAL_W-1:0]    rdata
);
	import bld_pkg::*;

	logic signed [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bld_ctrl.sv -----
module bld_ctrl #(
	parameter int DEPTH = bld_pkg::DEPTH_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  bld_pkg::req_word_t               req,
	output logic                             res_valid,
	output bld_pkg::rsp_word_t               res,
	input  logic                             rsp_space,
	output logic                             mem_we,
	output logic [IW-1:0]                    mem_waddr,
	output logic signed [bld_pkg::VAL_W-1:0] mem_wdata,
	output logic                             mem_re,
	output logic [IW-1:0]                    mem_raddr,
	input  logic signed [bld_pkg::VAL_W-1:0] mem_rdata
);
	import bld_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POPW = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_RDF  = 3'd3;
	localparam logic [2:0] S_RDB  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]              state_q;
	logic [IW-1:0]           head_q;
	logic [CW-1:0]           count_q;
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [ST_W-1:0]         status_q;
	logic signed [VAL_W-1:0] popped_q;
	logic signed [VAL_W-1:0] front_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           kept_q;
	logic [CW-1:0]           match_q;
	logic                    pend_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic          more;
	logic [IW-1:0] head_dec;

	// ring position k entries after the head, one compare and subtract
	function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] k);
		logic [IW:0] s;
		s = (IW+1)'(h) + (IW+1)'(k);
		if (s >= (IW+1)'(DEPTH)) begin
			s = s - (IW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign more      = (idx_q < count_q);
	assign head_dec  = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req.operation)
						OP_PUSH_FRONT: begin
							mem_we    = !full;
							mem_waddr = head_dec;
							mem_wdata = req.value;
						end
						OP_PUSH_BACK: begin
							mem_we    = !full;
							mem_waddr = slot(head_q, count_q);
							mem_wdata = req.value;
						end
						OP_POP_FRONT: begin
							mem_re = !empty;
						end
						OP_POP_BACK: begin
							mem_re    = !empty;
							mem_raddr = empty ? head_q : slot(head_q, count_q - CW'(1));
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				mem_re    = more;
				mem_raddr = more ? slot(head_q, idx_q) : head_q;
				// survivors move down to the next kept position
				if (pend_q && (mem_rdata != val_q) && (op_q == OP_ERASE)) begin
					mem_we    = 1'b1;
					mem_waddr = slot(head_q, kept_q);
					mem_wdata = mem_rdata;
				end
			end
			S_RDF: begin
				mem_re = 1'b1;
			end
			S_RDB: begin
				mem_re    = 1'b1;
				mem_raddr = empty ? head_q : slot(head_q, count_q - CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_q <= 1'b0;
						unique case (req.operation)
							OP_PUSH_FRONT: begin
								if (!full) begin
									head_q  <= head_dec;
									count_q <= count_q + CW'(1);
								end
								state_q <= S_RDF;
							end
							OP_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_RDF;
							end
							OP_POP_FRONT: begin
								if (empty) begin
									state_q <= S_RDF;
								end else begin
									head_q  <= slot(head_q, CW'(1));
									count_q <= count_q - CW'(1);
									state_q <= S_POPW;
								end
							end
							OP_POP_BACK: begin
								if (empty) begin
									state_q <= S_RDF;
								end else begin
									count_q <= count_q - CW'(1);
									state_q <= S_POPW;
								end
							end
							OP_ERASE, OP_COUNT: begin
								state_q <= empty ? S_RDF : S_SCAN;
							end
							default: begin
								state_q <= S_RDF;
							end
						endcase
					end
				end
				S_POPW: begin
					state_q <= S_RDF;
				end
				S_SCAN: begin
					pend_q <= more;
					if (!pend_q && !more) begin
						if (op_q == OP_ERASE) begin
							count_q <= kept_q;
						end
						state_q <= S_RDF;
					end
				end
				S_RDF: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_space) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= req.operation;
					val_q    <= req.value;
					popped_q <= '0;
					idx_q    <= '0;
					kept_q   <= '0;
					match_q  <= '0;
					status_q <= ST_OK;
					priority case (1'b1)
						(req.operation == OP_PUSH_FRONT) || (req.operation == OP_PUSH_BACK): begin
							if (full) begin
								status_q <= ST_FULL;
							end
						end
						(req.operation == OP_POP_FRONT) || (req.operation == OP_POP_BACK)
							|| (req.operation == OP_ERASE) || (req.operation == OP_COUNT): begin
							if (empty) begin
								status_q <= ST_UNDERFLOW;
							end
						end
						default: ;
					endcase
				end
			end
			S_POPW: begin
				popped_q <= mem_rdata;
			end
			S_SCAN: begin
				if (more) begin
					idx_q <= idx_q + CW'(1);
				end
				if (pend_q) begin
					if (mem_rdata == val_q) begin
						match_q <= match_q + CW'(1);
					end else begin
						kept_q <= kept_q + CW'(1);
					end
				end
				if (!pend_q && !more && (op_q == OP_ERASE) && (match_q == '0)) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_RDB: begin
				front_q <= mem_rdata;
			end
			default: ;
		endcase
	end

	assign res_valid        = (state_q == S_FIN);
	assign res.status       = status_q;
	assign res.popped_value = popped_q;
	assign res.match_count  = NUM_W'(match_q);
	assign res.list_size    = NUM_W'(count_q);
	assign res.is_empty     = empty;
	assign res.front_value  = empty ? '0 : front_q;
	assign res.back_value   = empty ? '0 : mem_rdata;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(IW+1)'(head_q) < (IW+1)'(DEPTH))
		else $error("head index outside store");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE || state_q == S_SCAN))
		else $error("store written outside push or erase");

	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (kept_q <= idx_q))
		else $error("erase compaction overtook the read pointer");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer idle right after accepting a word");
`endif

endmodule

// ----- design/bounded_list_deque_engine.sv -----
// Ordered list of up to DEPTH signed 32-bit words held in a single-port-read ring store with a
// head index and kept count; one response word per request word. The erase or count scan reads
// one entry per cycle through the store's single read port, and every operation ends with two
// reads for the front and back entries. A request can be taken while the previous result still
// waits in the output register. The store needs no clearing after reset.
module bounded_list_deque_engine #(
	parameter int DEPTH = bld_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bld_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bld_pkg::rsp_word_t rsp
);
	import bld_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic                    res_valid;
	rsp_word_t               res;
	logic                    rsp_space;
	logic                    rsp_valid_q;
	rsp_word_t               rsp_q;
	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	logic signed [VAL_W-1:0] mem_wdata;
	logic                    mem_re;
	logic [IW-1:0]           mem_raddr;
	logic signed [VAL_W-1:0] mem_rdata;

	assign rsp_space = !rsp_valid_q || rsp_ready;

	bld_ctrl #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.rsp_space (rsp_space),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bld_ram #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_space) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_space && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- dv/tb_bounded_list_deque_engine.sv -----
module tb_bounded_list_deque_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import bld_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_WORDS = 1600;
	localparam int STEADY_WORDS = 200;

	// operation codes the block must treat as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef enum {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIXED} drift_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	bounded_list_deque_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the list
	logic signed [VAL_W-1:0] deque_mem [DEPTH];
	int deque_head = 0;
	int deque_len = 0;
	int peak_len = 0;

	rsp_word_t deque_outcomes [$];

	int  error_count = 0;
	int  words_checked = 0;
	int  op_seen [8];
	int  status_seen [4];
	bit  no_idle = 1'b0;
	bit  req_up = 1'b0;
	logic signed [VAL_W-1:0] value_pool [6];

	function automatic rsp_word_t apply_deque_op(input req_word_t w);
		rsp_word_t r;
		int k;
		int kept;
		int hits;
		logic signed [VAL_W-1:0] v;
		r = '0;
		r.status = ST_OK;
		hits = 0;
		case (w.operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (deque_len >= DEPTH) begin
					r.status = ST_FULL;
				end else if (w.operation == OP_PUSH_FRONT) begin
					deque_head = (deque_head + DEPTH - 1) % DEPTH;
					deque_mem[deque_head] = w.value;
					deque_len++;
				end else begin
					deque_mem[(deque_head + deque_len) % DEPTH] = w.value;
					deque_len++;
				end
			end
			OP_POP_FRONT: begin
				if (deque_len == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					r.popped_value = deque_mem[deque_head];
					deque_head = (deque_head + 1) % DEPTH;
					deque_len--;
				end
			end
			OP_POP_BACK: begin
				if (deque_len == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					r.popped_value = deque_mem[(deque_head + deque_len - 1) % DEPTH];
					deque_len--;
				end
			end
			OP_ERASE: begin
				if (deque_len == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					// compact in place, head stays put
					kept = 0;
					for (k = 0; k < deque_len; k++) begin
						v = deque_mem[(deque_head + k) % DEPTH];
						if (v === w.value) begin
							hits++;
						end else begin
							deque_mem[(deque_head + kept) % DEPTH] = v;
							kept++;
						end
					end
					deque_len = kept;
					if (hits == 0)
						r.status = ST_NOT_FOUND;
				end
			end
			OP_COUNT: begin
				if (deque_len == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					for (k = 0; k < deque_len; k++)
						if (deque_mem[(deque_head + k) % DEPTH] === w.value)
							hits++;
				end
			end
			default: ;
		endcase
		r.match_count = hits[NUM_W-1:0];
		r.list_size = deque_len[NUM_W-1:0];
		r.is_empty = (deque_len == 0);
		if (deque_len != 0) begin
			r.front_value = deque_mem[deque_head];
			r.back_value = deque_mem[(deque_head + deque_len - 1) % DEPTH];
		end
		if (deque_len > peak_len)
			peak_len = deque_len;
		return r;
	endfunction

	task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
		req_word_t w;
		rsp_word_t r;
		int gap;
		w.operation = op;
		w.value = val;
		req_valid <= 1'b1;
		req <= w;
		req_up = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		r = apply_deque_op(w);
		deque_outcomes.push_back(r);
		op_seen[op]++;
		status_seen[r.status]++;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			req_valid <= 1'b0;
			req_up = 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic drop_req();
		if (req_up) begin
			req_valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	task automatic wait_for_drain();
		drop_req();
		while (deque_outcomes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		// mostly a small pool so erase and count find matches
		if ($urandom_range(0, 9) < 7)
			return value_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input drift_t drift);
		int roll;
		int push_pct;
		int pop_pct;
		roll = $urandom_range(0, 99);
		case (drift)
			DRIFT_GROW: begin
				push_pct = 70;
				pop_pct = 15;
			end
			DRIFT_SHRINK: begin
				push_pct = 20;
				pop_pct = 55;
			end
			default: begin
				push_pct = 40;
				pop_pct = 30;
			end
		endcase
		if (roll < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		if (roll < push_pct + pop_pct)
			return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		if (roll < 97)
			return $urandom_range(0, 1) ? OP_ERASE : OP_COUNT;
		return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
	endfunction

	// every operation but the pushes on an empty list, spare codes included
	task automatic test_empty_list();
		send_word(OP_POP_FRONT, 32'sd0);
		send_word(OP_POP_BACK, -32'sd1);
		send_word(OP_ERASE, 32'sd0);
		send_word(OP_COUNT, -32'sd1);
		send_word(OP_SPARE_LO, 32'sh7fffffff);
		send_word(OP_SPARE_HI, 32'sh80000000);
	endtask

	task automatic test_directed_ops();
		send_word(OP_PUSH_BACK, 32'sh7fffffff);
		send_word(OP_PUSH_FRONT, 32'sh80000000);
		send_word(OP_PUSH_BACK, 32'sd0);
		send_word(OP_PUSH_FRONT, -32'sd1);
		send_word(OP_PUSH_BACK, -32'sd1);
		send_word(OP_COUNT, -32'sd1);
		send_word(OP_COUNT, 32'sd5);
		send_word(OP_ERASE, 32'sd5);
		send_word(OP_ERASE, -32'sd1);
		send_word(OP_SPARE_LO, 32'sd1);
		send_word(OP_POP_FRONT, 32'sd0);
		send_word(OP_POP_BACK, 32'sd0);
		send_word(OP_SPARE_HI, -32'sd1);
		send_word(OP_PUSH_FRONT, 32'sd0);
		send_word(OP_ERASE, 32'sd0);
		send_word(OP_POP_BACK, 32'sd0);
		send_word(OP_POP_FRONT, 32'sd0);
	endtask

	// full list of one value: pushes dropped, count and erase see every entry
	task automatic test_fill_same_value();
		logic signed [VAL_W-1:0] fill;
		fill = $urandom;
		while (deque_len < DEPTH)
			send_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, fill);
		send_word(OP_PUSH_FRONT, ~fill);
		send_word(OP_PUSH_BACK, fill);
		send_word(OP_COUNT, fill);
		send_word(OP_ERASE, ~fill);
		send_word(OP_ERASE, fill);
	endtask

	task automatic test_fill_and_drain();
		while (deque_len < DEPTH)
			send_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
		send_word(OP_PUSH_BACK, pick_value());
		send_word(OP_COUNT, pick_value());
		while (deque_len > 0)
			send_word($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, 32'sd0);
		send_word(OP_POP_FRONT, 32'sd0);
	endtask

	task automatic test_random_mix(input int words);
		drift_t drift;
		int run;
		int n;
		n = 0;
		while (n < words) begin
			case ($urandom_range(0, 2))
				0: drift = DRIFT_GROW;
				1: drift = DRIFT_SHRINK;
				default: drift = DRIFT_MIXED;
			endcase
			run = $urandom_range(60, 150);
			repeat (run) begin
				send_word(pick_op(drift), pick_value());
				n++;
			end
		end
	endtask

	// receiver: random runs of ready and stall
	int  rx_hold = 0;
	bit  rx_open = 1'b1;
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			rx_open = ($urandom_range(0, 3) != 0);
			rx_hold = rx_open ? $urandom_range(1, 40) : $urandom_range(1, 18);
			rx_hold--;
		end
		rsp_ready <= rx_open || no_idle || !arst_n;
	end

	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			words_checked++;
			if (deque_outcomes.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result word with nothing outstanding: %p", $realtime, rsp);
			end else begin
				want = deque_outcomes.pop_front();
				if (want.status !== rsp.status || want.popped_value !== rsp.popped_value
						|| want.match_count !== rsp.match_count
						|| want.list_size !== rsp.list_size
						|| want.is_empty !== rsp.is_empty
						|| want.front_value !== rsp.front_value
						|| want.back_value !== rsp.back_value) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  exp st=%0d pop=%0d cnt=%0d size=%0d empty=%0d front=%0d back=%0d",
							want.status, want.popped_value, want.match_count, want.list_size,
							want.is_empty, want.front_value, want.back_value);
						$display("  got st=%0d pop=%0d cnt=%0d size=%0d empty=%0d front=%0d back=%0d",
							rsp.status, rsp.popped_value, rsp.match_count, rsp.list_size,
							rsp.is_empty, rsp.front_value, rsp.back_value);
					end
				end
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		value_pool[0] = 32'sd0;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sh7fffffff;
		value_pool[3] = 32'sh80000000;
		value_pool[4] = $urandom;
		value_pool[5] = $urandom;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_directed_ops();
		wait_for_drain();
		test_fill_same_value();
		test_fill_and_drain();
		test_random_mix(RANDOM_WORDS);
		wait_for_drain();
		// back-to-back traffic to finish
		no_idle = 1'b1;
		test_random_mix(STEADY_WORDS);
		wait_for_drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (deque_outcomes.size() != 0)
			error_count++;
		$display("Checked %0d result words; pushes %0d, pops %0d, erases %0d, counts %0d, spare %0d",
			words_checked, op_seen[OP_PUSH_FRONT] + op_seen[OP_PUSH_BACK],
			op_seen[OP_POP_FRONT] + op_seen[OP_POP_BACK], op_seen[OP_ERASE],
			op_seen[OP_COUNT], op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI]);
		$display("Underflow %0d, full %0d, not found %0d, largest list %0d, errors %0d",
			status_seen[ST_UNDERFLOW], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
			peak_len, error_count);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
